// ===== rtl/homogeneous_point_transform_core_macros.svh =====
// Assertion macros for the homogeneous point transform core.
// Used by the top level only; empty under synthesis.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_CORE_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define HPT_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpt assertion failed");
`define HPT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpt assertion failed");
`else
`define HPT_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define HPT_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/hpt_pkg.sv =====
// Shared types and constants of the homogeneous point transform core.
// No dependencies.
`timescale 1ns / 1ps
package hpt_pkg;

  localparam int DATA_W      = 32;
  localparam int LANES       = 4;
  localparam int ROW_W       = 2;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 128;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_XFORM = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                         kind;
    logic [ROW_W-1:0]              row;
    logic [LANES-1:0][DATA_W-1:0]  vals;
    logic                          last_flag;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MAC,
    BK_DRAIN,
    BK_DIV_SETUP,
    BK_DIV,
    BK_DIV_DONE,
    BK_OUT
  } back_state_t;

endpackage

// ===== rtl/hpt_front.sv =====
// Input stage: takes stream transfers, decodes them into queue entries.
// Depends on hpt_pkg.
`timescale 1ns / 1ps
module hpt_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [hpt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  output logic                               push,
  output hpt_pkg::entry_t                    push_entry,
  input  logic                               push_ready
);

  logic            valid_r, valid_nxt;
  hpt_pkg::entry_t ent_r, ent_nxt;
  logic            accept;

  assign in_tready  = !valid_r || push_ready;
  assign accept     = in_tvalid && in_tready;
  assign push       = valid_r && push_ready;
  assign push_entry = ent_r;

  always_comb begin
    valid_nxt = valid_r;
    ent_nxt   = ent_r;
    if (push) begin
      valid_nxt = 1'b0;
    end
    if (accept) begin
      valid_nxt         = 1'b1;
      ent_nxt.kind      = hpt_pkg::kind_t'(in_tuser);
      ent_nxt.row       = in_tdata[hpt_pkg::ROW_W-1:0];
      ent_nxt.vals      = in_tdata[hpt_pkg::ROW_W +: hpt_pkg::LANES*hpt_pkg::DATA_W];
      // final marker only means something on a point
      ent_nxt.last_flag = in_tlast && (in_tuser == 1'(hpt_pkg::KIND_XFORM));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    ent_r <= ent_nxt;
  end

endmodule

// ===== rtl/hpt_queue.sv =====
// Short FIFO between the input stage and the execution unit.
// Depends on hpt_pkg.
`timescale 1ns / 1ps
module hpt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hpt_pkg::entry_t push_entry,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output hpt_pkg::entry_t pop_entry
);

  localparam int PW = (hpt_pkg::QUEUE_DEPTH > 1) ? $clog2(hpt_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(hpt_pkg::QUEUE_DEPTH + 1);

  hpt_pkg::entry_t mem_r [hpt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != CW'(hpt_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_entry  = mem_r[rd_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(hpt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(hpt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/hpt_back.sv =====
// Execution unit: matrix store, shared multiply-accumulate, serial divider
// and output register. Depends on hpt_pkg.
`timescale 1ns / 1ps
module hpt_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  hpt_pkg::entry_t                    q_entry,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [hpt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);

  localparam int DW  = hpt_pkg::DATA_W;
  localparam int AW  = 2*DW + 2;
  localparam int NW  = DW + FRAC_BITS;
  localparam int CW  = $clog2(NW);
  localparam logic signed [AW-1:0] MAX_A = AW'(64'sh7FFF_FFFF);
  localparam logic signed [AW-1:0] MIN_A = -AW'(64'sh8000_0000);
  localparam logic [NW-1:0] LIM_POS = NW'(64'h7FFF_FFFF);
  localparam logic [NW-1:0] LIM_NEG = NW'(64'h8000_0000);
  localparam logic [DW-1:0] ONE_Q   = DW'(1) << FRAC_BITS;
  localparam logic [DW-1:0] MAX_Q   = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] MIN_Q   = 32'h8000_0000;

  hpt_pkg::back_state_t state_r, state_nxt;

  logic signed [DW-1:0]   mat_r [16];
  logic signed [DW-1:0]   mat_nxt [16];
  logic signed [DW-1:0]   pt_r [4];
  logic signed [DW-1:0]   pt_nxt [4];
  logic signed [DW-1:0]   res_r [4];
  logic signed [DW-1:0]   res_nxt [4];
  logic                   last_r, last_nxt;
  logic [3:0]             k_r, k_nxt, kp_r, kp_nxt;
  logic signed [2*DW-1:0] prod_r, prod_nxt;
  logic                   prodv_r, prodv_nxt;
  logic signed [AW-1:0]   acc_r, acc_nxt;
  logic [1:0]             di_r, di_nxt;
  logic [NW-1:0]          num_r, num_nxt, quo_r, quo_nxt;
  logic [DW:0]            rem_r, rem_nxt;
  logic [DW-1:0]          den_r, den_nxt;
  logic                   neg_r, neg_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   div_r, div_nxt;
  logic                   ov_r, ov_nxt;
  logic [hpt_pkg::OUT_TDATA_W-1:0] od_r, od_nxt;
  logic                   ou_r, ou_nxt, ol_r, ol_nxt;

  logic                   out_free;
  logic signed [AW-1:0]   acc_sum, acc_shift;
  logic signed [DW-1:0]   row_val;
  logic [DW:0]            rem_sh;
  logic                   ge;
  logic signed [DW-1:0]   p_sel;
  logic [DW-1:0]          p_mag, w_mag, q_sat;

  assign out_free   = !ov_r || out_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;
  assign q_pop      = (state_r == hpt_pkg::BK_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hpt_pkg::BK_IDLE: begin
        if (q_valid && q_entry.kind == hpt_pkg::KIND_XFORM) begin
          state_nxt = hpt_pkg::BK_MAC;
        end
      end
      hpt_pkg::BK_MAC: begin
        if (k_r == 4'hF) begin
          state_nxt = hpt_pkg::BK_DRAIN;
        end
      end
      hpt_pkg::BK_DRAIN:     state_nxt = hpt_pkg::BK_DIV_SETUP;
      hpt_pkg::BK_DIV_SETUP: begin
        state_nxt = (res_r[3] == '0) ? hpt_pkg::BK_OUT : hpt_pkg::BK_DIV;
      end
      hpt_pkg::BK_DIV: begin
        if (cnt_r == CW'(NW - 1)) begin
          state_nxt = hpt_pkg::BK_DIV_DONE;
        end
      end
      hpt_pkg::BK_DIV_DONE: begin
        state_nxt = (di_r == 2'd2) ? hpt_pkg::BK_OUT : hpt_pkg::BK_DIV_SETUP;
      end
      hpt_pkg::BK_OUT: begin
        if (out_free) begin
          state_nxt = hpt_pkg::BK_IDLE;
        end
      end
      default: state_nxt = hpt_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    mat_nxt   = mat_r;
    pt_nxt    = pt_r;
    res_nxt   = res_r;
    last_nxt  = last_r;
    k_nxt     = k_r;
    kp_nxt    = kp_r;
    prod_nxt  = prod_r;
    prodv_nxt = 1'b0;
    acc_nxt   = acc_r;
    di_nxt    = di_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    div_nxt   = div_r;
    ov_nxt    = ov_r && !out_tready;
    od_nxt    = od_r;
    ou_nxt    = ou_r;
    ol_nxt    = ol_r;

    acc_sum   = acc_r + {{2{prod_r[2*DW-1]}}, prod_r};
    acc_shift = acc_sum >>> FRAC_BITS;
    if (acc_shift > MAX_A) begin
      row_val = MAX_Q;
    end else if (acc_shift < MIN_A) begin
      row_val = MIN_Q;
    end else begin
      row_val = acc_shift[DW-1:0];
    end

    rem_sh = {rem_r[DW-1:0], num_r[NW-1]};
    ge     = (rem_sh >= {1'b0, den_r});

    p_sel = res_r[di_r];
    p_mag = p_sel[DW-1] ? (~p_sel + 1'b1) : p_sel;
    w_mag = res_r[3][DW-1] ? (~res_r[3] + 1'b1) : res_r[3];

    if (neg_r) begin
      q_sat = (quo_r > LIM_NEG) ? MIN_Q : (~quo_r[DW-1:0] + 1'b1);
    end else begin
      q_sat = (quo_r > LIM_POS) ? MAX_Q : quo_r[DW-1:0];
    end

    // one product per cycle; a row total settles as its fourth product lands
    if (prodv_r) begin
      if (kp_r[1:0] == 2'd3) begin
        res_nxt[kp_r[3:2]] = row_val;
        acc_nxt            = '0;
      end else begin
        acc_nxt = acc_sum;
      end
    end

    case (state_r)
      hpt_pkg::BK_IDLE: begin
        if (q_valid) begin
          if (q_entry.kind == hpt_pkg::KIND_LOAD) begin
            for (int i = 0; i < 4; i++) begin
              mat_nxt[{q_entry.row, 2'(i)}] = q_entry.vals[i];
            end
          end else begin
            for (int i = 0; i < 4; i++) begin
              pt_nxt[i] = q_entry.vals[i];
            end
            last_nxt = q_entry.last_flag;
            k_nxt    = '0;
            acc_nxt  = '0;
            di_nxt   = '0;
            div_nxt  = 1'b0;
          end
        end
      end
      hpt_pkg::BK_MAC: begin
        prod_nxt  = mat_r[k_r] * pt_r[k_r[1:0]];
        prodv_nxt = 1'b1;
        kp_nxt    = k_r;
        k_nxt     = k_r + 1'b1;
      end
      hpt_pkg::BK_DIV_SETUP: begin
        neg_nxt = p_sel[DW-1] ^ res_r[3][DW-1];
        num_nxt = {p_mag, FRAC_BITS'(0)};
        den_nxt = w_mag;
        rem_nxt = '0;
        quo_nxt = '0;
        cnt_nxt = '0;
      end
      hpt_pkg::BK_DIV: begin
        rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
        num_nxt = num_r << 1;
        quo_nxt = {quo_r[NW-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      hpt_pkg::BK_DIV_DONE: begin
        res_nxt[di_r] = q_sat;
        di_nxt        = di_r + 1'b1;
        if (di_r == 2'd2) begin
          res_nxt[3] = ONE_Q;
          div_nxt    = 1'b1;
        end
      end
      hpt_pkg::BK_OUT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = {res_r[3], res_r[2], res_r[1], res_r[0]};
          ou_nxt = div_r;
          ol_nxt = last_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hpt_pkg::BK_IDLE;
      prodv_r <= 1'b0;
      ov_r    <= 1'b0;
      acc_r   <= '0;
      for (int i = 0; i < 16; i++) begin
        mat_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      prodv_r <= prodv_nxt;
      ov_r    <= ov_nxt;
      acc_r   <= acc_nxt;
      mat_r   <= mat_nxt;
    end
    pt_r   <= pt_nxt;
    res_r  <= res_nxt;
    last_r <= last_nxt;
    k_r    <= k_nxt;
    kp_r   <= kp_nxt;
    prod_r <= prod_nxt;
    di_r   <= di_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    div_r  <= div_nxt;
    od_r   <= od_nxt;
    ou_r   <= ou_nxt;
    ol_r   <= ol_nxt;
  end

endmodule

// ===== rtl/homogeneous_point_transform_core.sv =====
// Load item: written into the matrix when the execution unit pops it; one load retired per
// cycle while no point is in progress. Point: products on the single 32x32 multiplier, a
// drain state, then three restoring divides of 32+FRAC_BITS steps, each with a setup and a
// done state; the divides are skipped when the product w is zero. The next item is popped
// from the queue only after the result has gone to the output register.
// Synchronous active-low reset clears the matrix, the queue and the output valid flag.
`timescale 1ns / 1ps
`include "homogeneous_point_transform_core_macros.svh"
module homogeneous_point_transform_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // row_select[1:0], value_a[33:2], value_b[65:34], value_c[97:66],
  // value_d[129:98], zero pad[135:130]
  input  logic [hpt_pkg::IN_TDATA_W-1:0]     in_tdata,
  // action
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
  output logic [hpt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // was_divided
  output logic                               out_tuser,
  output logic                               out_tlast
);

  localparam logic [hpt_pkg::DATA_W-1:0] ONE_Q = hpt_pkg::DATA_W'(1) << FRAC_BITS;

  logic            q_push, q_ready, q_pop, q_valid;
  hpt_pkg::entry_t push_entry, q_entry;

  hpt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .push       (q_push),
    .push_entry (push_entry),
    .push_ready (q_ready)
  );

  hpt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry)
  );

  hpt_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `HPT_ASSERT_IMPLY(a_pop_has_data, clk, rst_n, q_pop, q_valid)
  `HPT_ASSERT_NEXT(a_xform_holds_unit, clk, rst_n, q_pop && q_entry.kind == hpt_pkg::KIND_XFORM, !q_pop)
  `HPT_ASSERT_IMPLY(a_divided_w_one, clk, rst_n, out_tvalid && out_tuser, out_tdata[127:96] == ONE_Q)
  `HPT_ASSERT_IMPLY(a_raw_w_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata[127:96] == '0)

endmodule

// ===== tb/tb_homogeneous_point_transform_core.sv =====
// Self-checking testbench for homogeneous_point_transform_core: matrix row loads and
// point transforms with perspective divide, checked against an in-bench predictor.
// Depends on hpt_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb_homogeneous_point_transform_core;

  localparam int FRAC_BITS = 16;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_CYCLES = 1500;

  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN     = 32'h8000_0000;
  localparam logic signed [31:0] W_ONE = 32'sd1 <<< FRAC_BITS;

  typedef enum int {VAL_FULL, VAL_SMALL, VAL_ZERO, VAL_EXTREME, VAL_MEDIUM} value_mix_t;
  typedef enum int {MIX_PROJ, MIX_FULL, MIX_NO_W, MIX_ANY} matrix_mix_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               divided;
    logic               last_flag;
  } point_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [hpt_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [hpt_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  logic signed [31:0] matrix_coeff [4][4] = '{default: '0};
  point_result_t expected_points [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  bit tx_nogap = 1'b0;
  bit rx_nogap = 1'b0;
  int unsigned rx_hold_req = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_gap = 0;

  homogeneous_point_transform_core #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  function automatic logic signed [31:0] clamp_q32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -66'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic point_result_t transform_point(input logic signed [31:0] a, b, c, d,
                                                    input logic last_flag);
    point_result_t res;
    logic signed [31:0] pt [4];
    logic signed [31:0] prod [4];
    logic signed [65:0] acc;
    logic signed [65:0] num;
    int i;
    int j;
    pt[0] = a;
    pt[1] = b;
    pt[2] = c;
    pt[3] = d;
    for (i = 0; i < 4; i++) begin
      acc = '0;
      for (j = 0; j < 4; j++) acc = acc + matrix_coeff[i][j] * pt[j];
      prod[i] = clamp_q32(acc >>> FRAC_BITS);
    end
    res.divided = (prod[3] != 0);
    if (res.divided) begin
      for (i = 0; i < 3; i++) begin
        num = prod[i];
        num = num <<< FRAC_BITS;
        prod[i] = clamp_q32(num / prod[3]);
      end
      prod[3] = W_ONE;
    end
    res.x = prod[0];
    res.y = prod[1];
    res.z = prod[2];
    res.w = prod[3];
    res.last_flag = last_flag;
    return res;
  endfunction

  function automatic logic [31:0] draw_q(input value_mix_t mix);
    case (mix)
      VAL_FULL:   return $urandom;
      VAL_SMALL:  return $urandom_range(0, 2 ** 19) - 2 ** 18;
      VAL_MEDIUM: return $urandom_range(0, 2 ** 27) - 2 ** 26;
      VAL_EXTREME: begin
        case ($urandom_range(0, 5))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return Q_ONE;
          3: return Q_NEG_ONE;
          4: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return '0;
    endcase
  endfunction

  function automatic logic [31:0] draw_any();
    case ($urandom_range(0, 9))
      0, 1:    return draw_q(VAL_FULL);
      2, 3, 4, 5: return draw_q(VAL_SMALL);
      6:       return draw_q(VAL_ZERO);
      7:       return draw_q(VAL_EXTREME);
      default: return draw_q(VAL_MEDIUM);
    endcase
  endfunction

  function automatic logic [31:0] near_one_w();
    if ($urandom_range(0, 9) == 0) return draw_any();
    return Q_ONE + $urandom_range(0, 2 ** 15) - 2 ** 14;
  endfunction

  function automatic logic [31:0] matrix_entry(input matrix_mix_t mix, input int row, col);
    case (mix)
      MIX_PROJ: begin
        if (row < 3) return draw_q(VAL_SMALL);
        if (col == 3) return near_one_w();
        return ($urandom_range(0, 3) == 0) ? draw_q(VAL_SMALL) : '0;
      end
      MIX_FULL: return draw_q(VAL_FULL);
      MIX_NO_W: return (row == 3) ? '0 : draw_any();
      default:  return draw_any();
    endcase
  endfunction

  function automatic logic [31:0] point_coord(input bit proj, input int col);
    if (!proj) return draw_any();
    if (col == 3) return near_one_w();
    return ($urandom_range(0, 1) == 0) ? draw_q(VAL_SMALL) : draw_q(VAL_MEDIUM);
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // one transfer on the input side; updates the predictor when accepted
  task automatic send_item(input hpt_pkg::kind_t kind, input logic [1:0] row,
                           input logic [31:0] a, b, c, d, input logic last_flag);
    int unsigned gap;
    gap = tx_nogap ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, d, c, b, a, row};
    in_tuser  <= kind;
    in_tlast  <= last_flag;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == hpt_pkg::KIND_LOAD) begin
      matrix_coeff[row][0] = a;
      matrix_coeff[row][1] = b;
      matrix_coeff[row][2] = c;
      matrix_coeff[row][3] = d;
    end else begin
      expected_points.push_back(transform_point(a, b, c, d, last_flag));
    end
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // zero matrix after reset: w product is zero
    send_item(hpt_pkg::KIND_XFORM, 2'd3, Q_ONE, Q_NEG_ONE, Q_MAX, Q_ONE, 1'b1);
    // identity, tlast on a load is ignored
    send_item(hpt_pkg::KIND_LOAD, 2'd0, Q_ONE, 32'h0, 32'h0, 32'h0, 1'b1);
    send_item(hpt_pkg::KIND_LOAD, 2'd1, 32'h0, Q_ONE, 32'h0, 32'h0, 1'b0);
    send_item(hpt_pkg::KIND_LOAD, 2'd2, 32'h0, 32'h0, Q_ONE, 32'h0, 1'b0);
    send_item(hpt_pkg::KIND_LOAD, 2'd3, 32'h0, 32'h0, 32'h0, Q_ONE, 1'b0);
    send_item(hpt_pkg::KIND_XFORM, 2'd2, 32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000,
              Q_ONE, 1'b0);
    send_item(hpt_pkg::KIND_XFORM, 2'd1, 32'h0005_0000, Q_NEG_ONE, Q_MAX, 32'h0, 1'b1);
    send_item(hpt_pkg::KIND_XFORM, 2'd0, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_0001,
              32'h0002_0000, 1'b0);
    // divide by -1.0 overflows on the most negative x
    send_item(hpt_pkg::KIND_XFORM, 2'd0, Q_MIN, Q_MAX, Q_ONE, Q_NEG_ONE, 1'b0);
    // smallest nonzero w
    send_item(hpt_pkg::KIND_XFORM, 2'd3, Q_ONE, Q_NEG_ONE, 32'h0, 32'h0000_0001, 1'b1);
    // tiny w: nonzero sum that shifts to zero, and a negative one that floors to -1
    send_item(hpt_pkg::KIND_LOAD, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0000_0001, 1'b0);
    send_item(hpt_pkg::KIND_XFORM, 2'd0, Q_ONE, Q_ONE, Q_ONE, 32'h0000_7FFF, 1'b0);
    send_item(hpt_pkg::KIND_XFORM, 2'd0, Q_ONE, Q_NEG_ONE, 32'h0002_0000, 32'hFFFF_FFFF,
              1'b0);
    // saturating products
    send_item(hpt_pkg::KIND_LOAD, 2'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
    send_item(hpt_pkg::KIND_LOAD, 2'd1, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1);
    send_item(hpt_pkg::KIND_LOAD, 2'd2, Q_MAX, Q_MIN, 32'h0, Q_ONE, 1'b0);
    send_item(hpt_pkg::KIND_LOAD, 2'd3, 32'h0, 32'h0, 32'h0, Q_ONE, 1'b0);
    send_item(hpt_pkg::KIND_XFORM, 2'd1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
    send_item(hpt_pkg::KIND_XFORM, 2'd2, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1);
    send_item(hpt_pkg::KIND_XFORM, 2'd3, Q_MAX, Q_MIN, Q_ONE, 32'h0, 1'b0);
    send_item(hpt_pkg::KIND_LOAD, 2'd3, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
    send_item(hpt_pkg::KIND_XFORM, 2'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1);
    wait_results();
  endtask

  // receiver holds off while the sender keeps offering, so the core backs up
  task automatic test_output_stall();
    int i;
    tx_nogap = 1'b1;
    rx_hold_req = STALL_CYCLES;
    send_item(hpt_pkg::KIND_LOAD, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    for (i = 0; i < 16; i++)
      send_item(hpt_pkg::KIND_XFORM, 2'($urandom_range(0, 3)), draw_any(), draw_any(),
                draw_any(), draw_any(), 1'(i == 15));
    send_item(hpt_pkg::KIND_LOAD, 2'd3, 32'h0, 32'h0, 32'h0, Q_ONE, 1'b0);
    for (i = 0; i < 4; i++)
      send_item(hpt_pkg::KIND_XFORM, 2'($urandom_range(0, 3)), point_coord(1, 0),
                point_coord(1, 1), point_coord(1, 2), point_coord(1, 3), 1'b0);
    wait_results();
    tx_nogap = 1'b0;
  endtask

  // matrix loads followed by point batches, with stray reloads and partial loads
  task automatic test_random_stream(input int unsigned n_items);
    int unsigned sent;
    int style;
    int n_pts;
    int rows;
    int r;
    int k;
    matrix_mix_t mix;
    sent = 0;
    while (sent < n_items) begin
      tx_nogap = ($urandom_range(0, 4) == 0);
      rx_nogap = ($urandom_range(0, 4) == 0);
      style = $urandom_range(0, 9);
      if (style == 0) begin
        send_item(hpt_pkg::KIND_LOAD, 2'($urandom_range(0, 3)), draw_any(), draw_any(),
                  draw_any(), draw_any(), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        case ($urandom_range(0, 5))
          0, 1, 2: mix = MIX_PROJ;
          3:       mix = MIX_FULL;
          4:       mix = MIX_NO_W;
          default: mix = MIX_ANY;
        endcase
        rows = (style == 1) ? $urandom_range(1, 3) : 4;
        for (k = 0; k < rows; k++) begin
          r = (rows == 4) ? k : $urandom_range(0, 3);
          send_item(hpt_pkg::KIND_LOAD, 2'(r), matrix_entry(mix, r, 0),
                    matrix_entry(mix, r, 1), matrix_entry(mix, r, 2),
                    matrix_entry(mix, r, 3), 1'($urandom_range(0, 1)));
          sent++;
        end
        n_pts = $urandom_range(1, 12);
        for (k = 0; k < n_pts; k++) begin
          send_item(hpt_pkg::KIND_XFORM, 2'($urandom_range(0, 3)),
                    point_coord(mix == MIX_PROJ, 0), point_coord(mix == MIX_PROJ, 1),
                    point_coord(mix == MIX_PROJ, 2), point_coord(mix == MIX_PROJ, 3),
                    1'((k == n_pts - 1) || ($urandom_range(0, 7) == 0)));
          sent++;
        end
      end
    end
    tx_nogap = 1'b0;
    rx_nogap = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (rx_hold_req != 0) begin
        rx_hold = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (out_tready) begin
        if (out_tvalid) begin
          rx_gap = rx_nogap ? 0 : $urandom_range(0, 14);
          if (rx_gap != 0) out_tready <= 1'b0;
        end
      end else if (rx_gap != 0) begin
        rx_gap--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    point_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_points.size() == 0) begin
        $display("%0t mismatch: expected no transfer, actual tdata %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        compare_field("out_x", want.x, out_tdata[31:0]);
        compare_field("out_y", want.y, out_tdata[63:32]);
        compare_field("out_z", want.z, out_tdata[95:64]);
        compare_field("out_w", want.w, out_tdata[127:96]);
        compare_field("was_divided", 32'(want.divided), 32'(out_tuser));
        compare_field("final_out", 32'(want.last_flag), 32'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_output_stall();
    test_random_stream(1600);
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hpt_pkg.sv
rtl/hpt_front.sv
rtl/hpt_queue.sv
rtl/hpt_back.sv
rtl/homogeneous_point_transform_core.sv
tb/tb_homogeneous_point_transform_core.sv
